// ===== sv/tvsd_pkg.sv =====
// Shared types, codes and widths for the tagged value stream decoder.
package tvsd_pkg;

  localparam int MAX_DEPTH_DEFAULT = 16;

  localparam int BYTE_W  = 8;
  localparam int ROLE_W  = 2;
  localparam int KIND_W  = 4;
  localparam int NEST_W  = 5;
  localparam int VAL_W   = 64;
  localparam int ERR_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 2;
  localparam int TDATA_W = 80;   // nest_depth, data_byte, decoded_value, zero fill
  localparam int TUSER_W = 10;   // byte_role, value_kind, value_ready, item_done, error_code

  localparam logic [ROLE_W-1:0] ROLE_HEADER = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_LENGTH = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_SCALAR = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_RAW    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STRING = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ARRAY  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_TABLE  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_BLOB   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_FLOAT  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FALSE  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_TRUE   = 4'd7;
  localparam logic [KIND_W-1:0] KIND_NULL   = 4'd8;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_TAG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_SIZE = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_DEEP = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_INTEGERS   = 1'd1;

  // stack entry: remaining count, table flag, key seen flag
  typedef struct packed {
    logic [VAL_W-1:0] count;
    logic             is_table;
    logic             key_seen;
  } stack_entry_t;

  // kind for the prefixed length headers, indexed by bits 4:3
  function automatic logic [KIND_W-1:0] prefixed_kind(input logic [1:0] sub);
    logic [KIND_W-1:0] k;
    case (sub)
      2'd0:    k = KIND_BLOB;
      2'd1:    k = KIND_STRING;
      2'd2:    k = KIND_TABLE;
      default: k = KIND_ARRAY;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/tagged_value_stream_decoder_unit.sv =====
// Top level of the tagged value stream decoder.
// Each accepted word passes through S_PROC and S_EMIT before its result is registered on the output;
// when a value finishes inside containers, each stack entry examined adds an S_RD and an S_EV visit.
// A new word is accepted only in S_IDLE or as the previous result is emitted, so words do not overlap;
// the stack memory's registered read sets the per-level cost.
// Reset (rst, synchronous): expect a header, empty stack, no error; stack memory not cleared.
module tagged_value_stream_decoder_unit #(
  parameter int MAX_DEPTH = tvsd_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tvsd_pkg::BYTE_W-1:0]   s_tdata,   // in_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // nest_depth [4:0], data_byte [12:5], decoded_value [76:13], zero [79:77]
  output logic [tvsd_pkg::TDATA_W-1:0]  m_tdata,
  // byte_role [1:0], value_kind [5:2], value_ready [6], item_done [7], error_code [9:8]
  output logic [tvsd_pkg::TUSER_W-1:0]  m_tuser,
  output logic                          m_tlast,   // top_done
  input  logic                          cfg_we,
  input  logic [tvsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvsd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int SP_W = $clog2(MAX_DEPTH + 1);
  localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ENT_W = $bits(tvsd_pkg::stack_entry_t);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PROC = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    M_HEADER = 5'b00001,
    M_LENGTH = 5'b00010,
    M_SCALAR = 5'b00100,
    M_RAW    = 5'b01000,
    M_HALT   = 5'b10000
  } mode_t;

  state_t st, st_next;
  mode_t  mode, mode_next;

  logic [tvsd_pkg::KIND_W-1:0] kind, kind_next;
  logic [tvsd_pkg::VAL_W-1:0]  acc, acc_next;
  logic [3:0]                  left, left_next;
  logic [1:0]                  flog, flog_next;
  logic [tvsd_pkg::VAL_W-1:0]  raw_left, raw_left_next;
  logic [SP_W-1:0]             sp, sp_next;
  logic [tvsd_pkg::ERR_W-1:0]  sticky, sticky_next;

  logic [1:0] float_size_log2;
  logic       wide_integers;

  logic [tvsd_pkg::BYTE_W-1:0] byte_q;
  logic [tvsd_pkg::NEST_W-1:0] depth_q;

  logic [tvsd_pkg::ROLE_W-1:0] res_role, res_role_next;
  logic [tvsd_pkg::VAL_W-1:0]  res_dec, res_dec_next;
  logic res_ready, res_ready_next;
  logic res_item, res_item_next;
  logic res_top, res_top_next;

  // stack memory
  logic [ENT_W-1:0] mem [MAX_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  tvsd_pkg::stack_entry_t mem_wd;
  tvsd_pkg::stack_entry_t rd_q;
  logic [SP_W-1:0]  sp_m1;
  logic [AW-1:0]    top_addr;

  logic in_acc, out_free, emit;

  assign sp_m1    = sp - SP_W'(1);
  assign top_addr = sp_m1[AW-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (st == S_EMIT) && out_free;
  assign s_tready = (st == S_IDLE) || emit;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[top_addr];
  end

  function automatic logic size_ok(input logic [2:0] n, input logic wide);
    return (n <= 3'd2) || (n == 3'd3 && wide);
  endfunction

  always_comb begin
    logic        do_finish, do_body, err;
    logic [tvsd_pkg::ERR_W-1:0] ecode;
    logic [tvsd_pkg::VAL_W-1:0] body_len, acc_new, v, cnt_dec;
    logic [3:0]  size, left_new;
    logic [2:0]  idx, n, sub;

    st_next       = st;
    mode_next     = mode;
    kind_next     = kind;
    acc_next      = acc;
    left_next     = left;
    flog_next     = flog;
    raw_left_next = raw_left;
    sp_next       = sp;
    sticky_next   = sticky;
    res_role_next  = res_role;
    res_dec_next   = res_dec;
    res_ready_next = res_ready;
    res_item_next  = res_item;
    res_top_next   = res_top;
    mem_we = 1'b0;
    mem_wa = top_addr;
    mem_wd = rd_q;

    do_finish = 1'b0;
    do_body   = 1'b0;
    err       = 1'b0;
    ecode     = tvsd_pkg::ERR_NONE;
    body_len  = '0;
    n         = byte_q[2:0];
    sub       = byte_q[5:3];
    size      = 4'd1 << flog;
    idx       = 3'(size - left);
    acc_new   = acc | ({{(tvsd_pkg::VAL_W-tvsd_pkg::BYTE_W){1'b0}}, byte_q} << {idx, 3'b000});
    left_new  = (left != 4'd0) ? left - 4'd1 : 4'd0;
    v         = acc_new;
    cnt_dec   = rd_q.count - tvsd_pkg::VAL_W'(1);

    case (st)
      S_IDLE: begin
        if (in_acc) st_next = S_PROC;
      end
      S_PROC: begin
        res_role_next  = tvsd_pkg::ROLE_HEADER;
        res_dec_next   = '0;
        res_ready_next = 1'b0;
        res_item_next  = 1'b0;
        res_top_next   = 1'b0;
        case (mode)
          M_HEADER: begin
            if (!byte_q[7]) begin
              kind_next = tvsd_pkg::KIND_STRING;
              do_body   = 1'b1;
              body_len  = tvsd_pkg::VAL_W'(byte_q[6:0]);
            end else if (byte_q[7:5] == 3'b100 || byte_q[7:5] == 3'b101) begin
              kind_next = byte_q[5] ? tvsd_pkg::KIND_TABLE : tvsd_pkg::KIND_ARRAY;
              do_body   = 1'b1;
              body_len  = tvsd_pkg::VAL_W'(byte_q[4:0]);
            end else if (byte_q[7:4] != 4'hF) begin
              // 2^n-byte field follows
              if (!sub[2]) begin
                kind_next = tvsd_pkg::prefixed_kind(sub[1:0]);
                err = !size_ok(n, wide_integers);
                mode_next = M_LENGTH;
              end else if (sub == 3'd4) begin
                kind_next = tvsd_pkg::KIND_INT;
                err = !size_ok(n, wide_integers);
                mode_next = M_SCALAR;
              end else begin
                kind_next = tvsd_pkg::KIND_FLOAT;
                err = (n != {1'b0, float_size_log2});
                mode_next = M_SCALAR;
              end
              ecode     = tvsd_pkg::ERR_BAD_SIZE;
              flog_next = n[1:0];
              left_next = 4'd1 << n[1:0];
              acc_next  = '0;
            end else begin
              case (byte_q[3:0])
                4'd0: begin kind_next = tvsd_pkg::KIND_FALSE; do_finish = 1'b1; end
                4'd1: begin kind_next = tvsd_pkg::KIND_TRUE;  do_finish = 1'b1; end
                4'd2: begin kind_next = tvsd_pkg::KIND_NULL;  do_finish = 1'b1; end
                default: begin
                  kind_next = tvsd_pkg::KIND_STRING;
                  err   = 1'b1;
                  ecode = tvsd_pkg::ERR_BAD_TAG;
                end
              endcase
            end
          end
          M_LENGTH, M_SCALAR: begin
            res_role_next = (mode == M_LENGTH) ? tvsd_pkg::ROLE_LENGTH : tvsd_pkg::ROLE_SCALAR;
            acc_next  = acc_new;
            left_next = left_new;
            if (left_new == 4'd0) begin
              if (mode == M_SCALAR && kind == tvsd_pkg::KIND_INT) begin
                case (flog)
                  2'd0:    v = {{56{acc_new[7]}}, acc_new[7:0]};
                  2'd1:    v = {{48{acc_new[15]}}, acc_new[15:0]};
                  2'd2:    v = {{32{acc_new[31]}}, acc_new[31:0]};
                  default: v = acc_new;
                endcase
              end
              res_dec_next   = v;
              res_ready_next = 1'b1;
              if (mode == M_LENGTH) begin
                do_body  = 1'b1;
                body_len = v;
              end else begin
                do_finish = 1'b1;
              end
            end
          end
          M_RAW: begin
            res_role_next = tvsd_pkg::ROLE_RAW;
            raw_left_next = (raw_left != '0) ? raw_left - tvsd_pkg::VAL_W'(1) : raw_left;
            if (raw_left_next == '0) do_finish = 1'b1;
          end
          default: ;
        endcase

        if (do_body) begin
          if (body_len == '0) begin
            do_finish = 1'b1;
          end else if (kind_next == tvsd_pkg::KIND_STRING || kind_next == tvsd_pkg::KIND_BLOB) begin
            raw_left_next = body_len;
            mode_next     = M_RAW;
          end else if (sp >= SP_W'(MAX_DEPTH)) begin
            err   = 1'b1;
            ecode = tvsd_pkg::ERR_TOO_DEEP;
          end else begin
            mem_we = 1'b1;
            mem_wa = sp[AW-1:0];
            mem_wd.count    = body_len;
            mem_wd.is_table = (kind_next == tvsd_pkg::KIND_TABLE);
            mem_wd.key_seen = 1'b0;
            sp_next   = sp + SP_W'(1);
            mode_next = M_HEADER;
          end
        end

        if (err) begin
          if (sticky == tvsd_pkg::ERR_NONE) sticky_next = ecode;
          mode_next      = M_HALT;
          res_dec_next   = '0;
          res_ready_next = 1'b0;
        end

        if (do_finish) begin
          res_item_next = 1'b1;
          mode_next     = M_HEADER;
          if (sp == '0) begin
            res_top_next = 1'b1;
            st_next      = S_EMIT;
          end else begin
            st_next = S_RD;
          end
        end else begin
          st_next = S_EMIT;
        end
      end
      S_RD: st_next = S_EV;
      S_EV: begin
        if (rd_q.is_table && !rd_q.key_seen) begin
          mem_we = 1'b1;
          mem_wd.key_seen = 1'b1;
          st_next = S_EMIT;
        end else if (cnt_dec != '0) begin
          mem_we = 1'b1;
          mem_wd.count    = cnt_dec;
          mem_wd.key_seen = 1'b0;
          st_next = S_EMIT;
        end else begin
          sp_next = sp_m1;
          if (sp == SP_W'(1)) begin
            res_top_next = 1'b1;
            st_next      = S_EMIT;
          end else begin
            st_next = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (emit) st_next = in_acc ? S_PROC : S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      mode     <= M_HEADER;
      kind     <= '0;
      acc      <= '0;
      left     <= '0;
      flog     <= '0;
      raw_left <= '0;
      sp       <= '0;
      sticky   <= tvsd_pkg::ERR_NONE;
      float_size_log2 <= 2'd3;
      wide_integers   <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      st       <= st_next;
      mode     <= mode_next;
      kind     <= kind_next;
      acc      <= acc_next;
      left     <= left_next;
      flog     <= flog_next;
      raw_left <= raw_left_next;
      sp       <= sp_next;
      sticky   <= sticky_next;
      if (cfg_we) begin
        case (cfg_index)
          tvsd_pkg::CFG_FLOAT_SIZE_LOG2: float_size_log2 <= cfg_data;
          tvsd_pkg::CFG_WIDE_INTEGERS:   wide_integers   <= cfg_data[0];
          default: ;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_role  <= res_role_next;
    res_dec   <= res_dec_next;
    res_ready <= res_ready_next;
    res_item  <= res_item_next;
    res_top   <= res_top_next;
    if (in_acc) begin
      byte_q  <= s_tdata;
      depth_q <= tvsd_pkg::NEST_W'(sp);
    end
    if (emit) begin
      m_tdata <= {3'b000, res_dec, byte_q, depth_q};
      m_tuser <= {sticky, res_item, res_ready, kind, res_role};
      m_tlast <= res_top;
    end
  end

endmodule

// ===== sv/tvsd_checker.sv =====
// Port-level checks for the tagged value stream decoder, bound to the top level.
module tvsd_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tvsd_pkg::TDATA_W-1:0] m_tdata,
  input logic [tvsd_pkg::TUSER_W-1:0] m_tuser,
  input logic                         m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_top_is_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[7])
    else $error("top value done without item done");

  a_ready_role: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[6] |->
      (m_tuser[1:0] == tvsd_pkg::ROLE_LENGTH || m_tuser[1:0] == tvsd_pkg::ROLE_SCALAR))
    else $error("value ready on a header or raw byte");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[9:8] != tvsd_pkg::ERR_NONE |-> !m_tuser[6] && !m_tuser[7] && !m_tlast)
    else $error("decode flags set after an error");

endmodule

bind tagged_value_stream_decoder_unit tvsd_port_checks u_tvsd_port_checks (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
